[rtl/dape_pkg.sv]
// ----------------------------------------------------------------------------
// dape_pkg: shared codes and types of the DAG path enumerator
// Request, result and search phase codes, controller commands, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dape_pkg;

  // Request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_NEXT   = 2'd2;
  localparam logic [1:0] REQ_REWIND = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ACK       = 3'd0;
  localparam logic [2:0] ST_PATH_NODE = 3'd1;
  localparam logic [2:0] ST_NO_MORE   = 3'd2;
  localparam logic [2:0] ST_LIST_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_NODE  = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  // Search phases
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_RUN  = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;

  // Search stack geometry and counter limit
  localparam int          STACK_CAP = 16;
  localparam int          DEPTH_W   = 5;
  localparam int          SIDX_W    = 4;
  localparam logic [14:0] COUNT_MAX = 15'h7fff;

  // Controller commands
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_ACCEPT   = 4'd1;
  localparam logic [3:0] CMD_CLEAR    = 4'd2;
  localparam logic [3:0] CMD_ADD      = 4'd3;
  localparam logic [3:0] CMD_REWIND   = 4'd4;
  localparam logic [3:0] CMD_INIT     = 4'd5;
  localparam logic [3:0] CMD_DONE     = 4'd6;
  localparam logic [3:0] CMD_POP      = 4'd7;
  localparam logic [3:0] CMD_ADVANCE  = 4'd8;
  localparam logic [3:0] CMD_OVERFLOW = 4'd9;
  localparam logic [3:0] CMD_PUSH     = 4'd10;
  localparam logic [3:0] CMD_EMIT     = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic       sel_edge;  // degree lookup on the latched edge source
    logic       sel_emit;  // stack read at the emit index
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic [1:0] phase;
    logic       depth_zero;
    logic       cursor_end;
    logic       depth_full;
    logic       nb_target;
    logic       emit_last;
    logic       slot_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/dag_all_paths_enumerator.sv]
// ----------------------------------------------------------------------------
// dag_all_paths_enumerator: source-to-target path enumerator over a DAG
//
//   channel  dir  handshake                 payload
//   s_axis   in   s_axis_tvalid/tready      tuser req_type, tdata edge_from, edge_to
//   m_axis   out  m_axis_tvalid/tready      tuser status, tdata path_node,
//                                           path_number, tlast last
//   cfg      in   cfg_valid/cfg_ready       cfg_data node_count
//
// One request is in flight at a time. A request is accepted in S_IDLE and
// decoded in S_EXEC of the sequencer; a search step either pops in S_TOP or
// advances in S_TOP and pushes in S_PUSH (the neighbor table has a
// registered read port), and a found path is sent as one beat per node.
// Reset clears the degree counts and search state and sets the node count
// to 16 (or MAX_NODES if smaller); the neighbor table is not cleared.
// A stalled m_axis holds the sequencer only where it needs to place a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_all_paths_enumerator #(
  parameter int MAX_NODES  = 16,
  parameter int MAX_DEGREE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,       // node_count
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [3:0] edge_from, [7:4] edge_to
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [3:0] path_node, [18:4] path_number
  output logic [2:0]       m_axis_tuser,   // [2:0] status
  output logic             m_axis_tlast    // last
);

  dape_pkg::cmd_t  cmd;
  dape_pkg::stat_t stat;
  logic [3:0]      path_node;
  logic [14:0]     path_number;

  assign cfg_ready = 1'b1;

  dape_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dape_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_req     (s_axis_tuser),
    .in_from    (s_axis_tdata[3:0]),
    .in_to      (s_axis_tdata[7:4]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_node   (path_node),
    .out_last   (m_axis_tlast),
    .out_num    (path_number)
  );

  // Pack result fields, zero fill to whole bytes
  assign m_axis_tdata = {5'd0, path_number, path_node};

endmodule

`default_nettype wire

[rtl/dape_ram.sv]
// ----------------------------------------------------------------------------
// dape_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dape_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/dape_ctrl.sv]
// ----------------------------------------------------------------------------
// dape_ctrl: request and search sequencer
// Accepts one request at a time and steps the depth-first search through
// the datapath: pop, advance and push, then one beat per path node.
// ----------------------------------------------------------------------------
`default_nettype none

module dape_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dape_pkg::stat_t stat,
  output dape_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TOP  = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command
  always_comb begin
    state_next   = state;
    cmd.op       = dape_pkg::CMD_NONE;
    cmd.sel_edge = 1'b0;
    cmd.sel_emit = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = dape_pkg::CMD_ACCEPT;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.req)
          dape_pkg::REQ_CLEAR: begin
            if (stat.slot_free) begin
              cmd.op     = dape_pkg::CMD_CLEAR;
              state_next = S_IDLE;
            end
          end
          dape_pkg::REQ_ADD: begin
            cmd.sel_edge = 1'b1;
            if (stat.slot_free) begin
              cmd.op     = dape_pkg::CMD_ADD;
              state_next = S_IDLE;
            end
          end
          dape_pkg::REQ_NEXT: begin
            if (stat.phase == dape_pkg::PHASE_DONE) begin
              if (stat.slot_free) begin
                cmd.op     = dape_pkg::CMD_DONE;
                state_next = S_IDLE;
              end
            end else if (stat.phase == dape_pkg::PHASE_IDLE) begin
              cmd.op     = dape_pkg::CMD_INIT;
              state_next = S_TOP;
            end else begin
              state_next = S_TOP;
            end
          end
          default: begin
            if (stat.slot_free) begin
              cmd.op     = dape_pkg::CMD_REWIND;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_TOP: begin
        if (stat.depth_zero) begin
          if (stat.slot_free) begin
            cmd.op     = dape_pkg::CMD_DONE;
            state_next = S_IDLE;
          end
        end else if (stat.cursor_end) begin
          cmd.op = dape_pkg::CMD_POP;
        end else if (stat.depth_full) begin
          if (stat.slot_free) begin
            cmd.op     = dape_pkg::CMD_OVERFLOW;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = dape_pkg::CMD_ADVANCE;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.op     = dape_pkg::CMD_PUSH;
        state_next = stat.nb_target ? S_EMIT : S_TOP;
      end
      S_EMIT: begin
        cmd.sel_emit = 1'b1;
        if (stat.slot_free) begin
          cmd.op = dape_pkg::CMD_EMIT;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A push always follows the advance that fetched its neighbor
  a_push_after_top: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |-> $past(state) == S_TOP)
    else $error("push state entered without a preceding advance");

endmodule

`default_nettype wire

[rtl/dape_dp.sv]
// ----------------------------------------------------------------------------
// dape_dp: graph storage, search stack and result register
// Holds the neighbor lists, degree counts, node stack with cursors, search
// phase and path counter, and the output register for result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module dape_dp #(
  parameter int MAX_NODES  = 16,
  parameter int MAX_DEGREE = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  input  wire logic [4:0]     cfg_data,
  input  wire logic [1:0]     in_req,
  input  wire logic [3:0]     in_from,
  input  wire logic [3:0]     in_to,
  input  wire dape_pkg::cmd_t cmd,
  output dape_pkg::stat_t     stat,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [3:0]          out_node,
  output logic                out_last,
  output logic [14:0]         out_num
);

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NC_W      = $clog2(MAX_NODES + 1);
  localparam int CNT_W     = $clog2(MAX_DEGREE + 1);
  localparam int TBL_DEPTH = MAX_NODES * MAX_DEGREE;
  localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int NC_RESET  = (MAX_NODES < 16) ? MAX_NODES : 16;

  // Configuration and latched request
  logic [NC_W-1:0] node_count;
  logic [NC_W-1:0] cfg_nc;
  logic [1:0]      req;
  logic [3:0]      req_from;
  logic [3:0]      req_to;

  // Graph degrees and search state
  logic [CNT_W-1:0]             degree [MAX_NODES];
  logic [3:0]                   path_stack [dape_pkg::STACK_CAP];
  logic [CNT_W-1:0]             cursor_stack [dape_pkg::STACK_CAP];
  logic [dape_pkg::DEPTH_W-1:0] depth;
  logic [1:0]                   phase;
  logic [14:0]                  paths;
  logic [dape_pkg::SIDX_W-1:0]  emit_idx;

  // Lookups
  logic [dape_pkg::SIDX_W-1:0] top_idx;
  logic [dape_pkg::SIDX_W-1:0] rd_idx;
  logic [3:0]                  top_node;
  logic [CNT_W-1:0]            cur_c;
  logic [3:0]                  deg_node;
  logic [CNT_W-1:0]            deg_val;
  logic                        add_bad;
  logic                        add_full;
  logic                        add_ok;
  logic                        emit_last;

  // Neighbor table ports
  logic              tbl_wr_en;
  logic [ADDR_W-1:0] tbl_wr_addr;
  logic [ADDR_W-1:0] tbl_rd_addr;
  logic [3:0]        nb;

  // Result load
  logic        out_load;
  logic [2:0]  ld_status;
  logic [3:0]  ld_node;
  logic        ld_last;
  logic [14:0] ld_num;

  // Saturate a written node count into the supported range
  always_comb begin
    if (int'(cfg_data) < 2) begin
      cfg_nc = NC_W'(2);
    end else if (int'(cfg_data) > MAX_NODES) begin
      cfg_nc = NC_W'(MAX_NODES);
    end else begin
      cfg_nc = NC_W'(cfg_data);
    end
  end

  // Stack top, emit read and degree lookup
  assign top_idx  = dape_pkg::SIDX_W'(depth - dape_pkg::DEPTH_W'(1));
  assign rd_idx   = cmd.sel_emit ? emit_idx : top_idx;
  assign top_node = path_stack[rd_idx];
  assign cur_c    = cursor_stack[top_idx];
  assign deg_node = cmd.sel_edge ? req_from : top_node;
  assign deg_val  = (int'(deg_node) < MAX_NODES) ? degree[NODE_W'(deg_node)] : '0;

  // Edge checks
  assign add_bad  = (int'(req_from) >= int'(node_count)) ||
                    (int'(req_to) >= int'(node_count));
  assign add_full = (deg_val >= CNT_W'(MAX_DEGREE));
  assign add_ok   = !add_bad && !add_full;

  assign emit_last = ({1'b0, emit_idx} + dape_pkg::DEPTH_W'(1)) == depth;

  // Neighbor table addressing: row per node, slot per cursor
  assign tbl_wr_en   = (cmd.op == dape_pkg::CMD_ADD) && add_ok;
  assign tbl_wr_addr = ADDR_W'(req_from) * ADDR_W'(MAX_DEGREE) + ADDR_W'(deg_val);
  assign tbl_rd_addr = ADDR_W'(top_node) * ADDR_W'(MAX_DEGREE) + ADDR_W'(cur_c);

  dape_ram #(
    .WIDTH (4),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (req_to),
    .rd_addr (tbl_rd_addr),
    .rd_data (nb)
  );

  // Status toward the controller
  assign stat.req        = req;
  assign stat.phase      = phase;
  assign stat.depth_zero = (depth == '0);
  assign stat.cursor_end = (cur_c >= deg_val);
  assign stat.depth_full = (int'(depth) >= dape_pkg::STACK_CAP);
  assign stat.nb_target  = (int'(nb) == int'(node_count) - 1);
  assign stat.emit_last  = emit_last;
  assign stat.slot_free  = !out_valid || out_ready;

  // Select the result beat for this command
  always_comb begin
    out_load  = 1'b1;
    ld_status = dape_pkg::ST_ACK;
    ld_node   = 4'd0;
    ld_last   = 1'b1;
    ld_num    = 15'd0;
    case (cmd.op)
      dape_pkg::CMD_CLEAR, dape_pkg::CMD_REWIND: begin
        ld_status = dape_pkg::ST_ACK;
      end
      dape_pkg::CMD_ADD: begin
        if (add_bad) begin
          ld_status = dape_pkg::ST_BAD_NODE;
        end else if (add_full) begin
          ld_status = dape_pkg::ST_LIST_FULL;
        end else begin
          ld_status = dape_pkg::ST_ACK;
        end
      end
      dape_pkg::CMD_DONE: begin
        ld_status = dape_pkg::ST_NO_MORE;
        ld_num    = paths;
      end
      dape_pkg::CMD_OVERFLOW: begin
        ld_status = dape_pkg::ST_TOO_LONG;
        ld_num    = paths;
      end
      dape_pkg::CMD_EMIT: begin
        ld_status = dape_pkg::ST_PATH_NODE;
        ld_node   = top_node;
        ld_last   = emit_last;
        ld_num    = paths;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control state: configuration, degrees, depth, phase, count, beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NC_W'(NC_RESET);
      for (int n = 0; n < MAX_NODES; n++) begin
        degree[n] <= '0;
      end
      depth     <= '0;
      phase     <= dape_pkg::PHASE_IDLE;
      paths     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        node_count <= cfg_nc;
        depth      <= '0;
        phase      <= dape_pkg::PHASE_IDLE;
        paths      <= '0;
      end else begin
        case (cmd.op)
          dape_pkg::CMD_CLEAR: begin
            for (int n = 0; n < MAX_NODES; n++) begin
              degree[n] <= '0;
            end
            depth <= '0;
            phase <= dape_pkg::PHASE_IDLE;
            paths <= '0;
          end
          dape_pkg::CMD_REWIND: begin
            depth <= '0;
            phase <= dape_pkg::PHASE_IDLE;
            paths <= '0;
          end
          dape_pkg::CMD_ADD: begin
            if (add_ok) begin
              degree[NODE_W'(req_from)] <= deg_val + CNT_W'(1);
            end
          end
          dape_pkg::CMD_INIT: begin
            depth <= dape_pkg::DEPTH_W'(1);
            phase <= dape_pkg::PHASE_RUN;
          end
          dape_pkg::CMD_DONE, dape_pkg::CMD_OVERFLOW: begin
            depth <= '0;
            phase <= dape_pkg::PHASE_DONE;
          end
          dape_pkg::CMD_POP: begin
            depth <= depth - dape_pkg::DEPTH_W'(1);
          end
          dape_pkg::CMD_PUSH: begin
            depth <= depth + dape_pkg::DEPTH_W'(1);
          end
          dape_pkg::CMD_EMIT: begin
            if (emit_last) begin
              depth <= depth - dape_pkg::DEPTH_W'(1);
              if (paths != dape_pkg::COUNT_MAX) begin
                paths <= paths + 15'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Payload: latched request, stack entries, emit index, result fields
  always_ff @(posedge clk) begin
    if (cmd.op == dape_pkg::CMD_ACCEPT) begin
      req      <= in_req;
      req_from <= in_from;
      req_to   <= in_to;
    end
    if (cmd.op == dape_pkg::CMD_INIT) begin
      path_stack[0]   <= 4'd0;
      cursor_stack[0] <= '0;
    end
    if (cmd.op == dape_pkg::CMD_ADVANCE) begin
      cursor_stack[top_idx] <= cur_c + CNT_W'(1);
    end
    if (cmd.op == dape_pkg::CMD_PUSH) begin
      path_stack[dape_pkg::SIDX_W'(depth)]   <= nb;
      cursor_stack[dape_pkg::SIDX_W'(depth)] <= '0;
      emit_idx                               <= '0;
    end
    if (cmd.op == dape_pkg::CMD_EMIT) begin
      emit_idx <= emit_idx + dape_pkg::SIDX_W'(1);
    end
    if (out_load) begin
      out_status <= ld_status;
      out_node   <= ld_node;
      out_last   <= ld_last;
      out_num    <= ld_num;
    end
  end

  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    int'(depth) <= dape_pkg::STACK_CAP)
    else $error("search stack depth beyond capacity");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    phase == dape_pkg::PHASE_DONE |-> depth == '0)
    else $error("exhausted search left entries on the stack");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result beat overwritten before it was taken");

endmodule

`default_nettype wire

[test/dag_all_paths_enumerator_tb.sv]
// ----------------------------------------------------------------------------
// dag_all_paths_enumerator_tb: self-checking bench for the DAG path enumerator
// Builds graphs through add-edge requests, walks the path search with
// next-path, rewind and clear requests, and checks every result beat against
// a behavioral predictor of the search. Both streams idle at random, the
// node count is rewritten between phases, and a chain of full neighbor lists
// covers the list-full case.
// ----------------------------------------------------------------------------
`default_nettype none

module dag_all_paths_enumerator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES      = 16;
  localparam int MAX_DEGREE     = 16;
  localparam int RANDOM_ITEMS   = 240;
  localparam int CHAIN_REQUESTS = 20;
  localparam int SETTLE         = 8;
  localparam int LIMIT_CYCLES   = 4000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  node;
    logic        last;
    logic [14:0] number;
  } result_beat_t;

  // Predict the result beats of the path search and check them in order
  class path_tracker;
    logic [3:0]     nbr_list [MAX_NODES][MAX_DEGREE];
    logic [4:0]     degree [MAX_NODES];
    logic [3:0]     node_stack [dape_pkg::STACK_CAP];
    logic [4:0]     cursor [dape_pkg::STACK_CAP];
    int             depth;
    logic [1:0]     phase;
    logic [14:0]    found;
    int             node_count;
    int             mismatches;
    result_beat_t   pending_beats [$];

    function new();
      for (int i = 0; i < MAX_NODES; i++) degree[i] = '0;
      node_count = MAX_NODES;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      depth = 0;
      phase = dape_pkg::PHASE_IDLE;
      found = '0;
    endfunction

    function void expect_beat(logic [2:0] st, logic [3:0] nd, logic lst,
                              logic [14:0] num);
      result_beat_t b;
      b.status = st;
      b.node   = nd;
      b.last   = lst;
      b.number = num;
      pending_beats.push_back(b);
    endfunction

    // Saturate into the legal range; a write also rewinds the search
    function void note_node_count(logic [4:0] value);
      int v;
      v = int'(value);
      if (v < 2) v = 2;
      if (v > MAX_NODES) v = MAX_NODES;
      node_count = v;
      restart();
    endfunction

    // Resume the depth-first search up to the next path or its end
    function void walk_to_next_path();
      int          target;
      int          top;
      int          c;
      logic [3:0]  nb;
      target = node_count - 1;
      if (phase == dape_pkg::PHASE_IDLE) begin
        node_stack[0] = '0;
        cursor[0]     = '0;
        depth         = 1;
        phase         = dape_pkg::PHASE_RUN;
      end
      while (phase == dape_pkg::PHASE_RUN && depth > 0) begin
        top = int'(node_stack[depth-1]);
        c   = int'(cursor[depth-1]);
        if (c >= int'(degree[top])) begin
          depth--;
          continue;
        end
        cursor[depth-1] = 5'(c + 1);
        nb = nbr_list[top][c];
        if (depth >= dape_pkg::STACK_CAP) begin
          depth = 0;
          phase = dape_pkg::PHASE_DONE;
          expect_beat(dape_pkg::ST_TOO_LONG, '0, 1'b1, found);
          return;
        end
        node_stack[depth] = nb;
        cursor[depth]     = '0;
        depth++;
        if (int'(nb) == target) begin
          for (int i = 0; i < depth; i++)
            expect_beat(dape_pkg::ST_PATH_NODE, node_stack[i], i == depth - 1, found);
          if (found < dape_pkg::COUNT_MAX) found++;
          depth--;
          return;
        end
      end
      phase = dape_pkg::PHASE_DONE;
      depth = 0;
      expect_beat(dape_pkg::ST_NO_MORE, '0, 1'b1, found);
    endfunction

    function void note_request(logic [1:0] req, logic [3:0] src, logic [3:0] dst);
      case (req)
        dape_pkg::REQ_CLEAR: begin
          for (int i = 0; i < MAX_NODES; i++) degree[i] = '0;
          restart();
          expect_beat(dape_pkg::ST_ACK, '0, 1'b1, '0);
        end
        dape_pkg::REQ_ADD: begin
          if (int'(src) >= node_count || int'(dst) >= node_count) begin
            expect_beat(dape_pkg::ST_BAD_NODE, '0, 1'b1, '0);
          end else if (int'(degree[src]) >= MAX_DEGREE) begin
            expect_beat(dape_pkg::ST_LIST_FULL, '0, 1'b1, '0);
          end else begin
            nbr_list[src][degree[src]] = dst;
            degree[src] = degree[src] + 5'd1;
            expect_beat(dape_pkg::ST_ACK, '0, 1'b1, '0);
          end
        end
        dape_pkg::REQ_NEXT: walk_to_next_path();
        default: begin
          restart();
          expect_beat(dape_pkg::ST_ACK, '0, 1'b1, '0);
        end
      endcase
    endfunction

    function void check_beat(result_beat_t got);
      result_beat_t want;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: status %0d node %0d last %0b number %0d",
                   got.status, got.node, got.last, got.number);
        return;
      end
      want = pending_beats.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d node %0d last %0b number %0d,",
                   want.status, want.node, want.last, want.number,
                   " got status %0d node %0d last %0b number %0d",
                   got.status, got.node, got.last, got.number);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [3:0] edge_from, [7:4] edge_to
  logic [1:0]  s_axis_tuser = '0;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;        // [3:0] path_node, [18:4] path_number
  logic [2:0]  m_axis_tuser;        // [2:0] status
  logic        m_axis_tlast;

  path_tracker sb = new();
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int          cycles = 0;
  int          sent = 0;

  dag_all_paths_enumerator #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random don't-care field value
  function automatic logic [3:0] rnd4();
    return 4'($urandom);
  endfunction

  // Stall the result stream at random
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 20) begin
      m_axis_tready <= 1'b0;
      stall_left = idle_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    result_beat_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.node   = m_axis_tdata[3:0];
      got.last   = m_axis_tlast;
      got.number = m_axis_tdata[18:4];
      sb.check_beat(got);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] req, input logic [3:0] src,
                          input logic [3:0] dst);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {dst, src};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(req, src, dst);
    sent++;
  endtask

  // Drop valid, drain all results, let the block settle, then write
  task automatic write_node_count(input logic [4:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.note_node_count(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly forward edges, some back edges and self loops, some raw values
  task automatic add_random_edge();
    int n;
    int r;
    int src;
    int dst;
    n = sb.node_count;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      src = $urandom_range(0, n - 2);
      dst = $urandom_range(src + 1, n - 1);
    end else if (r < 88) begin
      src = $urandom_range(0, n - 1);
      dst = $urandom_range(0, src);
    end else begin
      src = $urandom_range(0, 15);
      dst = $urandom_range(0, 15);
    end
    send_req(dape_pkg::REQ_ADD, 4'(src), 4'(dst));
  endtask

  function automatic logic [4:0] pick_node_count();
    case ($urandom_range(0, 9))
      0:       return 5'($urandom_range(0, 1));
      1:       return 5'd16;
      2:       return 5'($urandom_range(17, 31));
      3:       return 5'd2;
      default: return 5'($urandom_range(3, 9));
    endcase
  endfunction

  initial begin
    int n_edges;
    int n_reqs;
    int r;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset node count of 16 accepts the highest node
    send_req(dape_pkg::REQ_ADD, 4'd15, 4'd15);
    send_req(dape_pkg::REQ_CLEAR, 4'd0, 4'd0);

    // Small diamond: every path, bad endpoints, exhaustion, rewind
    write_node_count(5'd4);
    send_req(dape_pkg::REQ_CLEAR, rnd4(), rnd4());
    send_req(dape_pkg::REQ_ADD, 4'd0, 4'd1);
    send_req(dape_pkg::REQ_ADD, 4'd0, 4'd2);
    send_req(dape_pkg::REQ_ADD, 4'd1, 4'd3);
    send_req(dape_pkg::REQ_ADD, 4'd2, 4'd3);
    send_req(dape_pkg::REQ_ADD, 4'd0, 4'd3);
    send_req(dape_pkg::REQ_ADD, 4'd4, 4'd0);
    send_req(dape_pkg::REQ_ADD, 4'd0, 4'd15);
    repeat (5) send_req(dape_pkg::REQ_NEXT, rnd4(), rnd4());
    send_req(dape_pkg::REQ_REWIND, rnd4(), rnd4());
    send_req(dape_pkg::REQ_NEXT, rnd4(), rnd4());
    // Append an edge while the search is under way
    send_req(dape_pkg::REQ_ADD, 4'd1, 4'd2);
    repeat (2) send_req(dape_pkg::REQ_NEXT, rnd4(), rnd4());

    // Two-node cycle overflows the stack, then the search stays exhausted
    write_node_count(5'd31);
    send_req(dape_pkg::REQ_CLEAR, 4'd0, 4'd0);
    send_req(dape_pkg::REQ_ADD, 4'd0, 4'd1);
    send_req(dape_pkg::REQ_ADD, 4'd1, 4'd0);
    repeat (2) send_req(dape_pkg::REQ_NEXT, rnd4(), rnd4());

    // Node count below range saturates to two nodes
    write_node_count(5'd0);
    send_req(dape_pkg::REQ_ADD, 4'd0, 4'd1);
    repeat (3) send_req(dape_pkg::REQ_NEXT, rnd4(), rnd4());

    // Random graphs and search sequences
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_node_count(pick_node_count());
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) send_req(dape_pkg::REQ_CLEAR, rnd4(), rnd4());
      n_edges = $urandom_range(1, 24);
      repeat (n_edges) add_random_edge();
      n_reqs = $urandom_range(2, 24);
      repeat (n_reqs) begin
        r = $urandom_range(0, 99);
        if (r < 6) send_req(dape_pkg::REQ_REWIND, rnd4(), rnd4());
        else if (r < 12) add_random_edge();
        else if (r < 14) send_req(dape_pkg::REQ_CLEAR, rnd4(), rnd4());
        else send_req(dape_pkg::REQ_NEXT, rnd4(), rnd4());
      end
    end
    quiet = 1'b0;

    // Chain of full neighbor lists: one more edge finds its list full
    write_node_count(5'd5);
    send_req(dape_pkg::REQ_CLEAR, 4'd0, 4'd0);
    for (int f = 0; f < 4; f++)
      repeat (MAX_DEGREE) send_req(dape_pkg::REQ_ADD, 4'(f), 4'(f + 1));
    send_req(dape_pkg::REQ_ADD, 4'd0, 4'd1);
    repeat (CHAIN_REQUESTS) send_req(dape_pkg::REQ_NEXT, rnd4(), rnd4());

    // Drain and let stray beats show up
    s_axis_tvalid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
